[hdl/qalu_pkg.sv]
// Shared types and constants of the Q24.8 fixed-point ALU.
// Used by qalu_mul, qalu_div and fixed_point_q24_8_alu; depends on nothing.
`default_nettype none
package qalu_pkg;

    localparam int W          = 32;
    localparam int FRAC       = 8;
    localparam int DVD_W      = W + FRAC;
    localparam int DIV_STAGES = DVD_W;
    localparam int IN_W       = 72;
    localparam int OUT_W      = 40;

    typedef enum logic [3:0] {
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GT, CMD_LT, CMD_GE, CMD_LE,
        CMD_EQ, CMD_NE, CMD_MIN, CMD_MAX, CMD_INC, CMD_DEC, CMD_FROM_INT, CMD_TO_INT
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic             valid;
        cmd_t             cmd;
        logic [W-1:0]     value;
        logic             flag;
        status_t          status;
        logic             quot_neg;
        logic [DVD_W-1:0] dividend;
        logic [W-1:0]     divisor;
    } side_t;

endpackage
`default_nettype wire

[hdl/qalu_mul.sv]
// Three-stage signed multiplier with round-half-away-from-zero scaling.
// Depends on qalu_pkg; merges the product into the word's sideband.
`default_nettype none
module qalu_mul (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic signed [qalu_pkg::W-1:0] a,
    input  wire logic signed [qalu_pkg::W-1:0] b,
    input  wire qalu_pkg::side_t        side_in,
    output qalu_pkg::side_t             side_out
);
    localparam int PW = 2 * qalu_pkg::W;

    qalu_pkg::side_t          s1_reg, s2_reg, s3_reg, s3_next;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic        [PW-1:0]     mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic        [PW-1:0]     rnd;
    logic        [PW-1:0]     lim;

    always_comb begin
        prod_next = a * b;
        neg_next  = prod_reg[PW-1];
        mag_next  = neg_next ? (~prod_reg + PW'(1)) : prod_reg;
    end

    always_comb begin
        rnd     = (mag_reg + (PW'(1) << (qalu_pkg::FRAC - 1))) >> qalu_pkg::FRAC;
        lim     = PW'(1) << (qalu_pkg::W - 1);
        s3_next = s2_reg;
        if (s2_reg.cmd == qalu_pkg::CMD_MUL) begin
            s3_next.value  = neg_reg ? qalu_pkg::W'(~rnd + PW'(1)) : rnd[qalu_pkg::W-1:0];
            s3_next.status = (neg_reg ? (rnd > lim) : (rnd >= lim))
                             ? qalu_pkg::ST_OVERFLOW : qalu_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
        end else if (en) begin
            s1_reg   <= side_in;
            prod_reg <= prod_next;
            s2_reg   <= s1_reg;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            s3_reg   <= s3_next;
        end
    end

    assign side_out = s3_reg;

endmodule
`default_nettype wire

[hdl/qalu_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on qalu_pkg; the quotient replaces the dividend in the sideband.
`default_nettype none
module qalu_div (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire qalu_pkg::side_t side_in,
    output qalu_pkg::side_t      side_out
);
    localparam int N = qalu_pkg::DIV_STAGES;
    localparam int W = qalu_pkg::W;

    qalu_pkg::side_t st_w  [N+1];
    logic [W-1:0]    rem_w [N+1];

    assign st_w[0]  = side_in;
    assign rem_w[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_stage
        qalu_pkg::side_t st_reg, st_next;
        logic [W-1:0]    rem_reg, rem_next;
        logic [W:0]      trial;

        always_comb begin
            trial    = {rem_w[k], st_w[k].dividend[qalu_pkg::DVD_W-1]}
                       - {1'b0, st_w[k].divisor};
            st_next  = st_w[k];
            rem_next = trial[W] ? {rem_w[k][W-2:0], st_w[k].dividend[qalu_pkg::DVD_W-1]}
                                : trial[W-1:0];
            st_next.dividend = {st_w[k].dividend[qalu_pkg::DVD_W-2:0], ~trial[W]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg.valid <= 1'b0;
            end else if (en) begin
                st_reg  <= st_next;
                rem_reg <= rem_next;
            end
        end

        assign st_w[k+1]  = st_reg;
        assign rem_w[k+1] = rem_reg;
    end

    assign side_out = st_w[N];

endmodule
`default_nettype wire

[hdl/fixed_point_q24_8_alu.sv]
// Every word passes through 45 registers in order: input register, 3 multiply stages,
// 40 divider stages, output register, whatever its command.
// Throughput: one word per cycle while the output is not stalled; the 40-stage divider sets the depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset (aresetn low, synchronous) clears all valid bits, so words in flight are dropped.
`default_nettype none
module fixed_point_q24_8_alu (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [qalu_pkg::IN_W-1:0]   s_tdata,  // cmd, operand_a, operand_b, pad
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [qalu_pkg::OUT_W-1:0]       m_tdata   // result_value, compare_flag, status, pad
);
    localparam int W     = qalu_pkg::W;
    localparam int DVD_W = qalu_pkg::DVD_W;

    logic                   en;
    logic                   in_valid_reg;
    qalu_pkg::cmd_t         cmd_reg;
    logic signed [W-1:0]    a_reg, b_reg;
    qalu_pkg::side_t        pre, mul_out, div_out;
    logic [W:0]             sum, dif;
    logic [W-1:0]           abs_a, abs_b;
    logic [DVD_W-1:0]       q, q_neg, lim;
    logic                   m_valid_reg;
    logic [W-1:0]           val_reg, val_next;
    logic                   flag_reg;
    qalu_pkg::status_t      stat_reg, stat_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
            cmd_reg      <= qalu_pkg::cmd_t'(s_tdata[3:0]);
            a_reg        <= s_tdata[35:4];
            b_reg        <= s_tdata[67:36];
        end
    end

    always_comb begin
        sum   = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
        dif   = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
        abs_a = a_reg[W-1] ? (W'(0) - a_reg) : a_reg;
        abs_b = b_reg[W-1] ? (W'(0) - b_reg) : b_reg;
        pre          = '0;
        pre.valid    = in_valid_reg;
        pre.cmd      = cmd_reg;
        pre.status   = qalu_pkg::ST_OK;
        pre.quot_neg = a_reg[W-1] ^ b_reg[W-1];
        pre.dividend = {abs_a, qalu_pkg::FRAC'(0)};
        pre.divisor  = abs_b;
        unique case (cmd_reg)
            qalu_pkg::CMD_ADD: begin
                pre.value  = sum[W-1:0];
                pre.status = (sum[W] ^ sum[W-1]) ? qalu_pkg::ST_OVERFLOW : qalu_pkg::ST_OK;
            end
            qalu_pkg::CMD_SUB: begin
                pre.value  = dif[W-1:0];
                pre.status = (dif[W] ^ dif[W-1]) ? qalu_pkg::ST_OVERFLOW : qalu_pkg::ST_OK;
            end
            qalu_pkg::CMD_MUL: pre.value = '0;
            qalu_pkg::CMD_DIV: begin
                if (b_reg == '0) pre.status = qalu_pkg::ST_DIVZERO;
            end
            qalu_pkg::CMD_GT:  pre.flag = a_reg >  b_reg;
            qalu_pkg::CMD_LT:  pre.flag = a_reg <  b_reg;
            qalu_pkg::CMD_GE:  pre.flag = a_reg >= b_reg;
            qalu_pkg::CMD_LE:  pre.flag = a_reg <= b_reg;
            qalu_pkg::CMD_EQ:  pre.flag = a_reg == b_reg;
            qalu_pkg::CMD_NE:  pre.flag = a_reg != b_reg;
            qalu_pkg::CMD_MIN: pre.value = (a_reg < b_reg) ? a_reg : b_reg;
            qalu_pkg::CMD_MAX: pre.value = (a_reg > b_reg) ? a_reg : b_reg;
            qalu_pkg::CMD_INC: begin
                pre.value  = a_reg + W'(1);
                pre.status = (a_reg == {1'b0, {(W-1){1'b1}}})
                             ? qalu_pkg::ST_OVERFLOW : qalu_pkg::ST_OK;
            end
            qalu_pkg::CMD_DEC: begin
                pre.value  = a_reg - W'(1);
                pre.status = (a_reg == {1'b1, {(W-1){1'b0}}})
                             ? qalu_pkg::ST_OVERFLOW : qalu_pkg::ST_OK;
            end
            qalu_pkg::CMD_FROM_INT: begin
                pre.value  = a_reg << qalu_pkg::FRAC;
                pre.status = (|a_reg[W-1:W-qalu_pkg::FRAC-1] && !(&a_reg[W-1:W-qalu_pkg::FRAC-1]))
                             ? qalu_pkg::ST_OVERFLOW : qalu_pkg::ST_OK;
            end
            qalu_pkg::CMD_TO_INT: pre.value = a_reg >>> qalu_pkg::FRAC;
            default: pre.value = '0;
        endcase
    end

    qalu_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .a        (a_reg),
        .b        (b_reg),
        .side_in  (pre),
        .side_out (mul_out)
    );

    qalu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (mul_out),
        .side_out (div_out)
    );

    always_comb begin
        q         = div_out.dividend;
        q_neg     = DVD_W'(0) - q;
        lim       = DVD_W'(1) << (W - 1);
        val_next  = div_out.value;
        stat_next = div_out.status;
        if (div_out.cmd == qalu_pkg::CMD_DIV && div_out.status != qalu_pkg::ST_DIVZERO) begin
            val_next  = div_out.quot_neg ? q_neg[W-1:0] : q[W-1:0];
            stat_next = (div_out.quot_neg ? (q > lim) : (q >= lim))
                        ? qalu_pkg::ST_OVERFLOW : qalu_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_out.valid;
            val_reg     <= val_next;
            flag_reg    <= div_out.flag;
            stat_reg    <= stat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, stat_reg, flag_reg, val_reg};

    a_flag_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && flag_reg |-> val_reg == '0 && stat_reg == qalu_pkg::ST_OK)
        else $error("compare flag with nonzero value or status");

    a_divzero_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && stat_reg == qalu_pkg::ST_DIVZERO |-> val_reg == '0)
        else $error("divide by zero with nonzero value");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> stat_reg == qalu_pkg::ST_OK || stat_reg == qalu_pkg::ST_DIVZERO
                        || stat_reg == qalu_pkg::ST_OVERFLOW)
        else $error("undefined status code");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("output valid after reset");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for fixed_point_q24_8_alu: directed corner words, then random words.
// Depends on qalu_pkg and the ALU top; each result is checked against an in-bench predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int  LATENCY     = 44;
    localparam longint MAX_CYC  = 400000;
    localparam logic [31:0] MAXP = 32'h7fffffff;
    localparam logic [31:0] MINN = 32'h80000000;

    typedef struct packed {
        qalu_pkg::status_t status;
        logic              flag;
        logic [31:0]       value;
    } alu_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    alu_result_t expected_q[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    longint      cycles = 0;

    fixed_point_q24_8_alu uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic alu_result_t wrap_result(longint v, qalu_pkg::status_t st);
        alu_result_t r;
        r.value  = v[31:0];
        r.flag   = 1'b0;
        r.status = st;
        if (st == qalu_pkg::ST_OK && (v > 64'sd2147483647 || v < -64'sd2147483648))
            r.status = qalu_pkg::ST_OVERFLOW;
        return r;
    endfunction

    function automatic alu_result_t compute_alu(qalu_pkg::cmd_t cmd, logic [31:0] ra,
                                                logic [31:0] rb);
        longint a, b, prod, mag, q;
        alu_result_t r;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        r = wrap_result(0, qalu_pkg::ST_OK);
        case (cmd)
            qalu_pkg::CMD_ADD: r = wrap_result(a + b, qalu_pkg::ST_OK);
            qalu_pkg::CMD_SUB: r = wrap_result(a - b, qalu_pkg::ST_OK);
            qalu_pkg::CMD_MUL: begin
                prod = a * b;
                mag  = (prod < 0) ? -prod : prod;
                mag  = (mag + 128) >>> qalu_pkg::FRAC;
                r = wrap_result((prod < 0) ? -mag : mag, qalu_pkg::ST_OK);
            end
            qalu_pkg::CMD_DIV: begin
                if (b == 0) begin
                    r = wrap_result(0, qalu_pkg::ST_DIVZERO);
                end else begin
                    q = (((a < 0) ? -a : a) << qalu_pkg::FRAC) / ((b < 0) ? -b : b);
                    r = wrap_result(((a < 0) != (b < 0)) ? -q : q, qalu_pkg::ST_OK);
                end
            end
            qalu_pkg::CMD_GT: r.flag = a > b;
            qalu_pkg::CMD_LT: r.flag = a < b;
            qalu_pkg::CMD_GE: r.flag = a >= b;
            qalu_pkg::CMD_LE: r.flag = a <= b;
            qalu_pkg::CMD_EQ: r.flag = a == b;
            qalu_pkg::CMD_NE: r.flag = a != b;
            qalu_pkg::CMD_MIN: r = wrap_result(a < b ? a : b, qalu_pkg::ST_OK);
            qalu_pkg::CMD_MAX: r = wrap_result(a > b ? a : b, qalu_pkg::ST_OK);
            qalu_pkg::CMD_INC: r = wrap_result(a + 1, qalu_pkg::ST_OK);
            qalu_pkg::CMD_DEC: r = wrap_result(a - 1, qalu_pkg::ST_OK);
            qalu_pkg::CMD_FROM_INT: r = wrap_result(a * 256, qalu_pkg::ST_OK);
            default: r = wrap_result(a >>> qalu_pkg::FRAC, qalu_pkg::ST_OK);
        endcase
        return r;
    endfunction

    task automatic send_word(qalu_pkg::cmd_t cmd, logic [31:0] a, logic [31:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, b, a, cmd};
        expected_q.push_back(compute_alu(cmd, a, b));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        alu_result_t got, exp_r;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[34:0];
            if (expected_q.size() == 0) begin
                $error("unexpected word %h", m_tdata);
                errors = errors + 1;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.value !== exp_r.value) begin
                    $error("result_value expected %h actual %h", exp_r.value, got.value);
                    errors = errors + 1;
                end
                if (got.flag !== exp_r.flag) begin
                    $error("compare_flag expected %b actual %b", exp_r.flag, got.flag);
                    errors = errors + 1;
                end
                if (got.status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, got.status);
                    errors = errors + 1;
                end
            end
        end
        if (cycles > MAX_CYC) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return MAXP - $urandom_range(3);
            1: return MINN + $urandom_range(3);
            2: return $urandom_range(511) - 256;
            3: return 32'($signed($urandom_range(65535) - 32768)) <<< $urandom_range(8);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        qalu_pkg::cmd_t c;
        c = c.first();
        do begin
            send_word(c, MAXP, MINN);
            c = c.next();
        end while (c != c.first());
        send_word(qalu_pkg::CMD_ADD, MAXP, 32'd1);
        send_word(qalu_pkg::CMD_SUB, MINN, 32'd1);
        send_word(qalu_pkg::CMD_MUL, MAXP, MAXP);
        send_word(qalu_pkg::CMD_MUL, 32'h00000180, 32'hffffff80);
        send_word(qalu_pkg::CMD_DIV, 32'h00000100, 32'd0);
        send_word(qalu_pkg::CMD_DIV, MINN, 32'hffffffff);
        send_word(qalu_pkg::CMD_DIV, 32'hfffffd00, 32'h00000200);
        send_word(qalu_pkg::CMD_EQ, 32'd5, 32'd5);
        send_word(qalu_pkg::CMD_MIN, 32'd7, 32'd7);
        send_word(qalu_pkg::CMD_INC, MAXP, 32'd0);
        send_word(qalu_pkg::CMD_DEC, MINN, 32'd0);
        send_word(qalu_pkg::CMD_FROM_INT, 32'h00800000, 32'd0);
        send_word(qalu_pkg::CMD_TO_INT, 32'hffffffff, 32'd0);
    endtask

    task automatic test_random(int count);
        repeat (count) send_word(qalu_pkg::cmd_t'($urandom_range(15)), rand_operand(),
                                 rand_operand());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 22;
        recv_idle_pct = 60;
        test_directed();
        test_random(330);
        send_idle_pct = 60;
        recv_idle_pct = 22;
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(340);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY * 2) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
